@@ src/text_console_writer_core_macros.svh @@
// assertion macros used by the checker of the text console writer
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, widths and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS_DEF = 80;
   localparam int ROWS_DEF = 25;

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int POS_W    = 11;
   localparam int CELL_DW  = 16;
   localparam int COLOR_W  = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_IDX   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_IDX   = 1'b1;
   localparam logic [COLOR_W-1:0]   FG_RESET     = 4'd15;
   localparam logic [COLOR_W-1:0]   BG_RESET     = 4'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT_CHAR   = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_SET_CURSOR = 2'd2,
      CMD_READ_CELL  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_COPY,
      ST_BLANK,
      ST_RESP
   } state_type;

endpackage

@@ src/tcw_screen_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Character cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH = tcw_pkg::COLS_DEF * tcw_pkg::ROWS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [tcw_pkg::CELL_DW-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [tcw_pkg::CELL_DW-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_DW-1:0] store_ff [DEPTH];
   logic [CELL_DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Teletype text console over a COLS x ROWS cell store, with scroll and clear.
// ----------------------------------------------------------------------------
// Put char or newline without scroll, set cursor and read cell go via the response
// state to the registered result strobe; busy is high for a single cycle and no
// request is taken while busy. A scroll adds a copy pass over the top ROWS-1 rows
// and a blanking of the bottom row; clear writes zeros to all COLS*ROWS cells;
// both go one cell per cycle. After reset a clearing pass runs with busy high and
// no result; csr writes are taken throughout. Results cannot be stalled.
module text_console_writer_core #(
   parameter int COLS = tcw_pkg::COLS_DEF,
   parameter int ROWS = tcw_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tcw_pkg::CMD_W-1:0]     req_command,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]     req_col_in,
   input  logic [tcw_pkg::ROW_W-1:0]     req_row_in,
   output logic                          rsp_valid,
   output logic [tcw_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic [tcw_pkg::CELL_DW-1:0]   rsp_cell_data,
   input  logic                          csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_wdata
);
   import tcw_pkg::*;

   localparam int CELLS   = COLS * ROWS;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int COPY_N  = COLS * (ROWS - 1);

   localparam logic [CELL_AW-1:0] CNT_LAST  = CELL_AW'(CELLS - 1);
   localparam logic [CELL_AW-1:0] CNT_COPY  = CELL_AW'(COPY_N);
   localparam logic [CELL_AW-1:0] COLS_A    = CELL_AW'(COLS);
   localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 1);

   state_type            state_ff, state_in;
   logic [CELL_AW-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic                 clr_resp_ff, clr_resp_in;
   logic                 rd_sel_ff, rd_sel_in;
   logic [COLOR_W-1:0]   fg_ff, bg_ff;
   logic                 rsp_valid_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [CELL_DW-1:0]   rsp_data_ff;

   cmd_type              cmd;
   logic                 accept;
   logic [COL_W-1:0]     req_col_c;
   logic [ROW_W-1:0]     req_row_c;
   logic [CELL_AW-1:0]   cur_idx;
   logic [CELL_AW-1:0]   req_idx;

   logic                 mem_we;
   logic [CELL_AW-1:0]   mem_waddr;
   logic [CELL_DW-1:0]   mem_wdata;
   logic [CELL_AW-1:0]   mem_raddr;
   logic [CELL_DW-1:0]   mem_rdata;

   assign cmd    = cmd_type'(req_command);
   assign accept = start && (state_ff == ST_IDLE);

   // out-of-range coordinates saturate
   assign req_col_c = ({1'b0, req_col_in} >= (COL_W + 1)'(COLS)) ? COL_LAST : req_col_in;
   assign req_row_c = ({1'b0, req_row_in} >= (ROW_W + 1)'(ROWS)) ? ROW_LAST : req_row_in;

   assign cur_idx = CELL_AW'(cur_row_ff) * COLS_A + CELL_AW'(cur_col_ff);
   assign req_idx = CELL_AW'(req_row_c) * COLS_A + CELL_AW'(req_col_c);

   // next state and cursor
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      clr_resp_in = clr_resp_ff;
      rd_sel_in   = rd_sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_sel_in = (cmd == CMD_READ_CELL);
               cnt_in    = '0;
               unique case (cmd)
                  CMD_PUT_CHAR: begin
                     if ((req_char_code == NEWLINE_CODE) || (cur_col_ff == COL_LAST)) begin
                        cur_col_in = '0;
                        if (cur_row_ff == ROW_LAST) begin
                           state_in = ST_COPY;
                        end else begin
                           cur_row_in = cur_row_ff + ROW_W'(1);
                           state_in   = ST_RESP;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + COL_W'(1);
                        state_in   = ST_RESP;
                     end
                  end
                  CMD_CLEAR: begin
                     cur_col_in  = '0;
                     cur_row_in  = '0;
                     clr_resp_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  CMD_SET_CURSOR: begin
                     cur_col_in = req_col_c;
                     cur_row_in = req_row_c;
                     state_in   = ST_RESP;
                  end
                  CMD_READ_CELL: begin
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end
         ST_COPY: begin
            // the last copy write lands while cnt points at the bottom row
            if (cnt_ff == CNT_COPY) begin
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end
         ST_BLANK: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + CELL_AW'(1);
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell store controls
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = '0;
      mem_raddr = req_idx;
      busy      = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_PUT_CHAR) && (req_char_code != NEWLINE_CODE)) begin
               mem_we    = 1'b1;
               mem_waddr = cur_idx;
               mem_wdata = {bg_ff, fg_ff, req_char_code};
            end
         end
         ST_CLEAR, ST_BLANK: begin
            mem_we = 1'b1;
         end
         ST_COPY: begin
            // read one row ahead, write the cell read in the cycle before
            mem_raddr = (cnt_ff == CNT_COPY) ? cnt_ff : cnt_ff + COLS_A;
            mem_we    = (cnt_ff != '0);
            mem_waddr = cnt_ff - CELL_AW'(1);
            mem_wdata = mem_rdata;
         end
         ST_RESP: begin
            mem_we = 1'b0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         clr_resp_ff <= 1'b0;
         rd_sel_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         clr_resp_ff <= clr_resp_in;
         rd_sel_ff   <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_FG_IDX) begin
            fg_ff <= csr_wdata;
         end
         if (csr_index == CSR_BG_IDX) begin
            bg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_RESP);
      end
   end

   // read data in the response cycle is from the read issued at accept
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP) begin
         rsp_pos_ff  <= POS_W'(cur_idx);
         rsp_data_ff <= rd_sel_ff ? mem_rdata : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_data  = rsp_data_ff;

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (CELL_AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

@@ src/tcw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module tcw_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import tcw_pkg::*;

   // an accepted request always makes the block busy in the cycle after
   `TCW_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // a result shows only once the block has finished the request
   `TCW_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")

   // one result per request, never in back-to-back cycles
   `TCW_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "repeated result strobe")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
